/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the line derivative filter modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds on every clock edge outside reset.
`define LDF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition never occurs outside reset.
`define LDF_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

/* hw/rtl/ldf_pkg.sv */
// Types, constants and helpers shared by the line derivative filter modules.
package ldf_pkg;

	localparam int SAMPLE_WIDTH = 16;
	localparam int FRAC_BITS    = 8;
	localparam int WIN_DEPTH    = 7;
	localparam int OUT_W        = 25;
	localparam int COUNT_W      = 3;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 3'd7;

	// Numerator: coefficient magnitudes sum to at most 12, so four guard bits
	localparam int NUM_W = SAMPLE_WIDTH + 4;
	// Scaled magnitude: numerator magnitude shifted up by the fraction bits
	localparam int SC_W  = NUM_W + FRAC_BITS;

	// Reciprocal constants for division by ten and by twenty-eight
	localparam int RECIP_SHIFT = SC_W + 1;
	localparam int RECIP_W     = RECIP_SHIFT - 3;
	localparam logic [RECIP_W-1:0] RECIP_10 = RECIP_W'((64'd1 << RECIP_SHIFT) / 10);
	localparam logic [RECIP_W-1:0] RECIP_28 = RECIP_W'((64'd1 << RECIP_SHIFT) / 28);

	// Result queue depth
	localparam int QDEPTH = 8;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = QPTR_W + 1;
	localparam logic [QCNT_W-1:0] QDEPTH_C = QCNT_W'(QDEPTH);

	// Mode register codes
	localparam logic [2:0] MODE_CENTRAL = 3'd0;
	localparam logic [2:0] MODE_NEXT    = 3'd1;
	localparam logic [2:0] MODE_SG5     = 3'd2;
	localparam logic [2:0] MODE_SG7     = 3'd3;
	localparam logic [2:0] MODE_PASS    = 3'd4;

	typedef enum logic [1:0] {
		DIV_1,
		DIV_2,
		DIV_10,
		DIV_28
	} div_sel_t;

	// Per-item bookkeeping: result count, main result present, line end
	typedef struct packed {
		logic [2:0] n_out;
		logic       main;
		logic       last;
	} meta_t;

	// Numerator word handed from the front end to the scaler
	typedef struct packed {
		logic                    valid;
		logic signed [NUM_W-1:0] num;
		div_sel_t                div;
		meta_t                   meta;
	} num_word_t;

	// Queue entry: finished value plus bookkeeping
	typedef struct packed {
		logic signed [OUT_W-1:0] value;
		meta_t                   meta;
	} entry_t;

	// Left and right half-widths of the window for a mode
	function automatic logic [3:0] half_widths(input logic [2:0] m);
		logic [3:0] hw;
		unique case (m)
			MODE_CENTRAL: hw = {2'd1, 2'd1};
			MODE_NEXT:    hw = {2'd0, 2'd1};
			MODE_SG5:     hw = {2'd2, 2'd2};
			MODE_SG7:     hw = {2'd3, 2'd3};
			default:      hw = {2'd0, 2'd0};
		endcase
		return hw;
	endfunction

endpackage

/* hw/rtl/ldf_front.sv */
// Front end: mode register, sample window, line position, classification and numerator.
module ldf_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  mode_we,
	input  logic [2:0]                            mode_wdata,
	input  logic                                  accept,
	input  logic signed [ldf_pkg::SAMPLE_WIDTH-1:0] sample,
	input  logic                                  line_end,
	output logic                                  busy_s1,
	output ldf_pkg::num_word_t                    word_s2
);
	import ldf_pkg::*;

	logic [2:0]                     mode_q;
	logic signed [SAMPLE_WIDTH-1:0] window_q [WIN_DEPTH];
	logic [COUNT_W-1:0]             count_q;

	logic                           valid_s1;
	logic [2:0]                     mode_s1;
	logic                           zero_s1;
	meta_t                          meta_s1;

	logic [3:0]                     hw;
	logic [1:0]                     hl, hr;
	logic                           main;
	logic                           zero;
	logic [2:0]                     flush;
	logic [2:0]                     i_plus;
	logic signed [NUM_W-1:0]        w [WIN_DEPTH];
	logic signed [NUM_W-1:0]        num;
	div_sel_t                       div;

	// Hold the mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_CENTRAL;
		end else if (mode_we) begin
			mode_q <= mode_wdata;
		end
	end

	// Classify the incoming word against its line position
	always_comb begin
		hw     = half_widths(mode_q);
		hl     = hw[3:2];
		hr     = hw[1:0];
		i_plus = count_q + 3'd1;
		main   = ({1'b0, count_q} >= {2'b00, hr});
		zero   = ({1'b0, count_q} < ({2'b00, hl} + {2'b00, hr}));
		if (!line_end) begin
			flush = 3'd0;
		end else if ({1'b0, i_plus} < {2'b00, hr} && count_q != COUNT_MAX) begin
			flush = i_plus;
		end else begin
			flush = {1'b0, hr};
		end
	end

	// Advance the window and the line position on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < WIN_DEPTH; k++) begin
				window_q[k] <= '0;
			end
			count_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept && (main || line_end);
			if (accept) begin
				for (int k = WIN_DEPTH - 1; k > 0; k--) begin
					window_q[k] <= window_q[k-1];
				end
				window_q[0] <= sample;
				if (line_end) begin
					count_q <= '0;
				end else if (count_q != COUNT_MAX) begin
					count_q <= i_plus;
				end
			end
		end
	end

	// Capture the classification beside the updated window
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1       <= mode_q;
			zero_s1       <= zero;
			meta_s1.n_out <= {2'b00, main} + flush;
			meta_s1.main  <= main;
			meta_s1.last  <= line_end;
		end
	end

	// Form the numerator from the window as it stands after this word
	always_comb begin
		for (int k = 0; k < WIN_DEPTH; k++) begin
			w[k] = NUM_W'(window_q[k]);
		end
		unique case (mode_s1)
			MODE_CENTRAL: begin
				num = w[0] - w[2];
				div = DIV_2;
			end
			MODE_NEXT: begin
				num = w[0] - w[1];
				div = DIV_1;
			end
			MODE_SG5: begin
				num = (w[0] <<< 1) + w[1] - w[3] - (w[4] <<< 1);
				div = DIV_10;
			end
			MODE_SG7: begin
				num = (w[0] <<< 1) + w[0] + (w[1] <<< 1) + w[2]
				    - w[4] - (w[5] <<< 1) - (w[6] <<< 1) - w[6];
				div = DIV_28;
			end
			default: begin
				num = w[0];
				div = DIV_1;
			end
		endcase
		if (zero_s1) begin
			num = '0;
		end
	end

	// Register the numerator word for the scaler
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_s2 <= '0;
		end else begin
			word_s2.valid <= valid_s1;
			word_s2.num   <= num;
			word_s2.div   <= div;
			word_s2.meta  <= meta_s1;
		end
	end

	assign busy_s1 = valid_s1;

endmodule

/* hw/rtl/ldf_scale.sv */
// Scaler: fixed-point scaling and rounded division by a constant via reciprocal.
module ldf_scale (
	input  logic               clk,
	input  logic               arst_n,
	input  ldf_pkg::num_word_t word_s2,
	output logic               busy_s3,
	output logic               push,
	output ldf_pkg::entry_t    push_entry
);
	import ldf_pkg::*;

	logic                        sign;
	logic [NUM_W-1:0]            mag;
	logic [SC_W-1:0]             x;
	logic [SC_W-1:0]             half;
	logic [RECIP_W-1:0]          recip;
	logic [SC_W+RECIP_W-1:0]     prod;

	logic                        valid_s3;
	logic                        sign_s3;
	logic [SC_W-1:0]             x_s3;
	logic [SC_W-1:0]             q0_s3;
	div_sel_t                    div_s3;
	meta_t                       meta_s3;

	logic [SC_W-1:0]             den;
	logic [SC_W-1:0]             rem;
	logic [SC_W-1:0]             q;
	logic [OUT_W-1:0]            q_out;

	// Take the magnitude, scale it, add half the divisor, multiply by the reciprocal
	always_comb begin
		sign = word_s2.num[NUM_W-1];
		mag  = sign ? NUM_W'(-word_s2.num) : NUM_W'(word_s2.num);
		unique case (word_s2.div)
			DIV_1:   half = '0;
			DIV_2:   half = SC_W'(1);
			DIV_10:  half = SC_W'(5);
			default: half = SC_W'(14);
		endcase
		recip = (word_s2.div == DIV_10) ? RECIP_10 : RECIP_28;
		x     = (SC_W'(mag) << FRAC_BITS) + half;
		prod  = (SC_W + RECIP_W)'(x) * (SC_W + RECIP_W)'(recip);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= word_s2.valid;
		end
	end

	always_ff @(posedge clk) begin
		sign_s3 <= sign;
		x_s3    <= x;
		q0_s3   <= SC_W'(prod >> RECIP_SHIFT);
		div_s3  <= word_s2.div;
		meta_s3 <= word_s2.meta;
	end

	// Correct the estimated quotient by one step and restore the sign
	always_comb begin
		den = (div_s3 == DIV_10) ? SC_W'(10) : SC_W'(28);
		rem = x_s3 - SC_W'(q0_s3 * den);
		unique case (div_s3)
			DIV_1:   q = x_s3;
			DIV_2:   q = x_s3 >> 1;
			default: q = (rem >= den) ? q0_s3 + SC_W'(1) : q0_s3;
		endcase
		q_out = OUT_W'(q);
	end

	assign push             = valid_s3;
	assign push_entry.value = sign_s3 ? -$signed(q_out) : $signed(q_out);
	assign push_entry.meta  = meta_s3;
	assign busy_s3          = valid_s3;

endmodule

/* hw/rtl/ldf_queue.sv */
// Result queue between the arithmetic pipeline and the output sequencer.
`include "assert_macros.svh"

module ldf_queue (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  ldf_pkg::entry_t               push_entry,
	input  logic                          pop,
	output logic                          head_valid,
	output ldf_pkg::entry_t               head_entry,
	output logic [ldf_pkg::QCNT_W-1:0]    count
);
	import ldf_pkg::*;

	entry_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	// Store pushed entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			count_q <= count_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

	assign head_valid = (count_q != '0);
	assign head_entry = mem_q[rd_ptr_q];
	assign count      = count_q;

	`LDF_NEVER(a_queue_overflow, push && !pop && count_q == QDEPTH_C, "push into full queue")
	`LDF_NEVER(a_queue_underflow, pop && count_q == '0, "pop from empty queue")

endmodule

/* hw/rtl/ldf_back.sv */
// Output sequencer: expands each queue entry into its results and drives the output register.
`include "assert_macros.svh"

module ldf_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                head_valid,
	input  ldf_pkg::entry_t                     head_entry,
	output logic                                pop,
	output logic                                deriv_valid,
	input  logic                                deriv_ready,
	output logic signed [ldf_pkg::OUT_W-1:0]    derivative,
	output logic                                line_last
);
	import ldf_pkg::*;

	logic [1:0]              sub_q;
	logic                    out_valid_q;
	logic signed [OUT_W-1:0] deriv_q;
	logic                    last_q;

	logic                    load;
	logic                    final_word;

	// Load the output register whenever it is empty or being drained
	assign load       = !out_valid_q || deriv_ready;
	assign final_word = ({1'b0, sub_q} + 3'd1 == head_entry.meta.n_out);
	assign pop        = head_valid && load && final_word;

	// Step through the results of the head entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= head_valid;
			if (head_valid) begin
				sub_q <= final_word ? 2'd0 : sub_q + 2'd1;
			end
		end
	end

	// Main result first, then flushed zeros; flag the last of the line
	always_ff @(posedge clk) begin
		if (load && head_valid) begin
			deriv_q <= (sub_q == 2'd0 && head_entry.meta.main) ? head_entry.value : '0;
			last_q  <= head_entry.meta.last && final_word;
		end
	end

	assign deriv_valid = out_valid_q;
	assign derivative  = deriv_q;
	assign line_last   = last_q;

	`LDF_ASSERT(a_pop_restarts, pop |=> sub_q == 2'd0, "entry sequencer not rewound after pop")

endmodule

/* hw/rtl/line_derivative_filter_core.sv */
// Top level of the line derivative filter.
//
// Samples of one image line enter on the sample channel (sample_valid /
// sample_ready), line_end set on the last one. Results leave on the deriv
// channel (deriv_valid / deriv_ready): one derivative per sample, signed with
// 8 fraction bits, line_last set on the final result of a line.
// The mode register is written through mode_we / mode_wdata while idle.
// Throughput: one sample per cycle while sample_ready is high. Results
// trail by the pipeline plus the window lag of the selected mode (0 to 3
// samples); the line end word releases up to 4 results in a burst.
// The 3-stage arithmetic pipeline and the 8-entry result queue share a credit
// count: sample_ready drops when queued plus in-flight words reach 8, which
// is what holds input back while the receiver stalls or a flush burst drains.
// Reset clears the mode (central difference), the window, the line position,
// the queue pointers and occupancy, and the output valid flag and sequencer.
`include "assert_macros.svh"

module line_derivative_filter_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  mode_we,
	input  logic [2:0]                            mode_wdata,
	input  logic                                  sample_valid,
	output logic                                  sample_ready,
	input  logic signed [ldf_pkg::SAMPLE_WIDTH-1:0] sample,
	input  logic                                  line_end,
	output logic                                  deriv_valid,
	input  logic                                  deriv_ready,
	output logic signed [ldf_pkg::OUT_W-1:0]      derivative,
	output logic                                  line_last
);
	import ldf_pkg::*;

	logic              accept;
	logic              busy_s1;
	logic              busy_s3;
	num_word_t         word_s2;
	logic              push;
	entry_t            push_entry;
	logic              pop;
	logic              head_valid;
	entry_t            head_entry;
	logic [QCNT_W-1:0] q_count;
	logic [QCNT_W:0]   credit_used;

	// Count queued words plus those still in the pipeline
	assign credit_used  = {1'b0, q_count} + (QCNT_W + 1)'(busy_s1)
	                    + (QCNT_W + 1)'(word_s2.valid) + (QCNT_W + 1)'(busy_s3);
	assign sample_ready = (credit_used < {1'b0, QDEPTH_C});
	assign accept       = sample_valid && sample_ready;

	ldf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.mode_we    (mode_we),
		.mode_wdata (mode_wdata),
		.accept     (accept),
		.sample     (sample),
		.line_end   (line_end),
		.busy_s1    (busy_s1),
		.word_s2    (word_s2)
	);

	ldf_scale u_scale (
		.clk        (clk),
		.arst_n     (arst_n),
		.word_s2    (word_s2),
		.busy_s3    (busy_s3),
		.push       (push),
		.push_entry (push_entry)
	);

	ldf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.count      (q_count)
	);

	ldf_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_entry  (head_entry),
		.pop         (pop),
		.deriv_valid (deriv_valid),
		.deriv_ready (deriv_ready),
		.derivative  (derivative),
		.line_last   (line_last)
	);

	`LDF_NEVER(a_credit_bound, credit_used > {1'b0, QDEPTH_C}, "credit count exceeds queue depth")

endmodule
